>>> design/kmeans_clustering_top_defines.svh
// Assertion macros for the k-means clustering block.
// Depends on nothing; included by the top level.
`ifndef KMEANS_CLUSTERING_TOP_DEFINES_SVH
`define KMEANS_CLUSTERING_TOP_DEFINES_SVH

// same-cycle implication
`define KMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define KMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/kmc_pkg.sv
// Shared constants, payload structs and helper types of the k-means block.
// Depends on nothing; used by the top level, the lane, the merge stage and the divider.
package kmc_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_DIMS     = 4;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_POINTS   = 1024;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int KW           = IDX_W + 1;
  localparam int DIM_W        = $clog2(MAX_DIMS + 1);
  localparam int DIDX_W       = $clog2(MAX_DIMS);
  localparam int PADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W        = PADDR_W + 1;
  localparam int ACC_W        = COORD_W + PADDR_W;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int DIST_W       = 2 * DIFF_W + 2;
  localparam int PT_W         = COORD_W * MAX_DIMS;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int ITER_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd3;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;
  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_CLASS    = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [MAX_DIMS-1:0] point_t;
  typedef logic [MAX_DIMS-1:0][ACC_W-1:0] acc_vec_t;

  typedef struct packed {
    logic   func;
    coord_t coord_0;
    coord_t coord_1;
    coord_t coord_2;
    coord_t coord_3;
    logic   last_point;
  } in_t;

  typedef struct packed {
    logic              result_kind;
    logic [IDX_W-1:0]  cluster_index;
    coord_t            cent_0;
    coord_t            cent_1;
    coord_t            cent_2;
    coord_t            cent_3;
    logic              converged;
    logic [ITER_W-1:0] iterations_run;
    logic              last_result;
  } out_t;

  typedef struct packed {
    logic clear;
    logic acc;
  } lane_ctl_t;

endpackage

>>> design/kmeans_clustering_top.sv
// Loads take one transfer a cycle while the block is idle; a classification
// answer passes the lane and merge registers to the output register, and the
// next item can transfer once that answer is loaded. A fit takes a setup step,
// then per iteration a lane sweep over the stored points, a pipeline drain, one
// pass of the shared divider per used coordinate of each non-empty cluster and
// a convergence check; the centroids then leave one a cycle unless the output
// stalls. Reset restores register defaults, zeroes the point count and centroids.
`include "kmeans_clustering_top_defines.svh"
module kmeans_clustering_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  kmc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output kmc_pkg::out_t                 out_data,
  input  logic                          cfg_wr_en,
  input  logic [kmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmc_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLS_WAIT = 4'd1;
  localparam logic [3:0] S_CLS_OUT  = 4'd2;
  localparam logic [3:0] S_INIT     = 4'd3;
  localparam logic [3:0] S_SWEEP    = 4'd4;
  localparam logic [3:0] S_DRAIN    = 4'd5;
  localparam logic [3:0] S_UPDATE   = 4'd6;
  localparam logic [3:0] S_UPD_WAIT = 4'd7;
  localparam logic [3:0] S_CHECK    = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  localparam int PIPE = 4;

  logic [3:0]                          state;
  logic [kmc_pkg::KW-1:0]              num_clusters;
  logic [kmc_pkg::DIM_W-1:0]           dims_in_use;
  logic [15:0]                         tolerance;
  logic [kmc_pkg::ITER_W-1:0]          max_iterations;
  logic [kmc_pkg::KW-1:0]              k;
  logic [kmc_pkg::DIM_W-1:0]           d;
  logic [kmc_pkg::ITER_W-1:0]          limit;

  logic [kmc_pkg::CNT_W-1:0]           pcount;
  logic [kmc_pkg::CNT_W-1:0]           rd_ptr;
  logic                                rd_valid;
  logic                                cls_go;
  kmc_pkg::point_t                     cls_pt;
  kmc_pkg::point_t                     in_pt;
  kmc_pkg::point_t                     ram_rdata;
  kmc_pkg::point_t                     lane_pt;
  kmc_pkg::point_t                     first_pts [kmc_pkg::MAX_CLUSTERS];
  kmc_pkg::point_t                     cent      [kmc_pkg::MAX_CLUSTERS];
  kmc_pkg::point_t                     pt_pipe   [PIPE];
  logic [PIPE-2:0]                     vpipe;
  logic                                rd_issue;
  logic                                ram_we;

  logic [kmc_pkg::MAX_CLUSTERS-1:0][kmc_pkg::DIST_W-1:0] distance;
  logic [kmc_pkg::MAX_CLUSTERS-1:0]    lane_en;
  kmc_pkg::acc_vec_t                   lane_sums  [kmc_pkg::MAX_CLUSTERS];
  logic [kmc_pkg::CNT_W-1:0]           lane_count [kmc_pkg::MAX_CLUSTERS];
  kmc_pkg::lane_ctl_t                  lane_ctl   [kmc_pkg::MAX_CLUSTERS];
  logic                                lane_clear;
  logic                                merge_valid;
  logic [kmc_pkg::IDX_W-1:0]           merge_idx;
  logic                                acc_en;

  logic [kmc_pkg::IDX_W-1:0]           cidx;
  logic [kmc_pkg::DIDX_W-1:0]          jdx;
  logic [2:0]                          drain_cnt;
  logic [kmc_pkg::ITER_W-1:0]          iters;
  logic                                conv;
  logic                                div_start;
  logic                                div_done;
  kmc_pkg::coord_t                     div_quot;
  logic signed [kmc_pkg::DIFF_W-1:0]   chg;
  logic [kmc_pkg::DIFF_W-1:0]          chg_abs;
  logic                                load_out;
  logic                                last_c;
  logic                                last_j;

  assign k = (num_clusters == '0) ? kmc_pkg::KW'(1) :
             (num_clusters > kmc_pkg::KW'(kmc_pkg::MAX_CLUSTERS)) ?
             kmc_pkg::KW'(kmc_pkg::MAX_CLUSTERS) : num_clusters;
  assign d = (dims_in_use == '0) ? kmc_pkg::DIM_W'(1) :
             (dims_in_use > kmc_pkg::DIM_W'(kmc_pkg::MAX_DIMS)) ?
             kmc_pkg::DIM_W'(kmc_pkg::MAX_DIMS) : dims_in_use;
  assign limit = (max_iterations == '0) ? kmc_pkg::ITER_W'(1) : max_iterations;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= kmc_pkg::KW'(2);
      dims_in_use    <= kmc_pkg::DIM_W'(2);
      tolerance      <= '0;
      max_iterations <= kmc_pkg::ITER_W'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kmc_pkg::REG_NUM_CLUSTERS: num_clusters   <= cfg_data[kmc_pkg::KW-1:0];
        kmc_pkg::REG_DIMS_IN_USE:  dims_in_use    <= cfg_data[kmc_pkg::DIM_W-1:0];
        kmc_pkg::REG_TOLERANCE:    tolerance      <= cfg_data[15:0];
        kmc_pkg::REG_MAX_ITER:     max_iterations <= cfg_data[kmc_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pt[0] = in_data.coord_0;
  assign in_pt[1] = in_data.coord_1;
  assign in_pt[2] = in_data.coord_2;
  assign in_pt[3] = in_data.coord_3;

  kmc_pkg::point_t in_masked;
  always_comb begin
    for (int j = 0; j < kmc_pkg::MAX_DIMS; j++) begin
      in_masked[j] = (kmc_pkg::DIM_W'(j) < d) ? in_pt[j] : '0;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign ram_we   = in_valid && in_ready && (in_data.func == kmc_pkg::FUNC_LOAD) &&
                    (pcount < kmc_pkg::CNT_W'(kmc_pkg::MAX_POINTS));
  assign rd_issue = (state == S_SWEEP) && (rd_ptr < pcount);

  kmc_ram #(
    .WIDTH (kmc_pkg::PT_W),
    .DEPTH (kmc_pkg::MAX_POINTS)
  ) u_point_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pcount[kmc_pkg::PADDR_W-1:0]),
    .wdata (in_masked),
    .raddr (rd_ptr[kmc_pkg::PADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign lane_pt    = cls_go ? cls_pt : ram_rdata;
  assign lane_clear = (state == S_INIT) ||
                      ((state == S_CHECK) && !(conv || (iters + kmc_pkg::ITER_W'(1)) >= limit));
  assign acc_en     = merge_valid && ((state == S_SWEEP) || (state == S_DRAIN));

  genvar gi;
  generate
    for (gi = 0; gi < kmc_pkg::MAX_CLUSTERS; gi++) begin : g_lane
      assign lane_en[gi]        = kmc_pkg::KW'(gi) < k;
      assign lane_ctl[gi].clear = lane_clear;
      assign lane_ctl[gi].acc   = acc_en && (merge_idx == kmc_pkg::IDX_W'(gi));
      kmc_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .dims     (d),
        .pt       (lane_pt),
        .cent     (cent[gi]),
        .distance (distance[gi]),
        .ctl      (lane_ctl[gi]),
        .acc_pt   (pt_pipe[PIPE-1]),
        .sums     (lane_sums[gi]),
        .count    (lane_count[gi])
      );
    end
  endgenerate

  kmc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vpipe[PIPE-2]),
    .en       (lane_en),
    .distance (distance),
    .valid    (merge_valid),
    .idx      (merge_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE-3:0], rd_valid | cls_go};
    end
    pt_pipe[0] <= lane_pt;
    for (int s = 1; s < PIPE; s++) begin
      pt_pipe[s] <= pt_pipe[s-1];
    end
  end

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(lane_sums[cidx][jdx])),
    .divisor  (lane_count[cidx]),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign div_start = (state == S_UPDATE) && (lane_count[cidx] != '0);
  assign chg       = kmc_pkg::DIFF_W'(div_quot) - kmc_pkg::DIFF_W'($signed(cent[cidx][jdx]));
  assign chg_abs   = (chg < 0) ? kmc_pkg::DIFF_W'(-chg) : kmc_pkg::DIFF_W'(chg);
  assign last_c    = ({1'b0, cidx} + kmc_pkg::KW'(1)) == k;
  assign last_j    = ({1'b0, jdx} + kmc_pkg::DIM_W'(1)) == d;
  assign load_out  = ((state == S_CLS_OUT) || (state == S_EMIT)) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pcount   <= '0;
      rd_valid <= 1'b0;
      cls_go   <= 1'b0;
      for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) begin
        cent[i] <= '0;
      end
    end else begin
      rd_valid <= rd_issue;
      cls_go   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.func == kmc_pkg::FUNC_CLASSIFY) begin
              cls_pt <= in_masked;
              cls_go <= 1'b1;
              state  <= S_CLS_WAIT;
            end else begin
              if (ram_we) begin
                pcount <= pcount + kmc_pkg::CNT_W'(1);
                if (pcount < kmc_pkg::CNT_W'(kmc_pkg::MAX_CLUSTERS)) begin
                  first_pts[pcount[kmc_pkg::IDX_W-1:0]] <= in_masked;
                end
              end
              if (in_data.last_point) begin
                state <= S_INIT;
              end
            end
          end
        end
        S_CLS_WAIT: begin
          if (merge_valid) begin
            cidx  <= merge_idx;
            state <= S_CLS_OUT;
          end
        end
        S_CLS_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        S_INIT: begin
          for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) begin
            for (int j = 0; j < kmc_pkg::MAX_DIMS; j++) begin
              cent[i][j] <= (kmc_pkg::KW'(i) < k && kmc_pkg::CNT_W'(i) < pcount &&
                             kmc_pkg::DIM_W'(j) < d) ? first_pts[i][j] : '0;
            end
          end
          iters  <= '0;
          conv   <= 1'b1;
          rd_ptr <= '0;
          state  <= S_SWEEP;
        end
        S_SWEEP: begin
          if (rd_issue) begin
            rd_ptr <= rd_ptr + kmc_pkg::CNT_W'(1);
          end else begin
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 3'd1;
          if (drain_cnt == 3'd7) begin
            cidx  <= '0;
            jdx   <= '0;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (div_start) begin
            state <= S_UPD_WAIT;
          end else if (last_c) begin
            state <= S_CHECK;
          end else begin
            cidx <= cidx + kmc_pkg::IDX_W'(1);
            jdx  <= '0;
          end
        end
        S_UPD_WAIT: begin
          if (div_done) begin
            if (chg_abs > {1'b0, tolerance}) begin
              conv <= 1'b0;
            end
            cent[cidx][jdx] <= div_quot;
            if (last_j) begin
              jdx <= '0;
              if (last_c) begin
                state <= S_CHECK;
              end else begin
                cidx  <= cidx + kmc_pkg::IDX_W'(1);
                state <= S_UPDATE;
              end
            end else begin
              jdx   <= jdx + kmc_pkg::DIDX_W'(1);
              state <= S_UPDATE;
            end
          end
        end
        S_CHECK: begin
          iters <= iters + kmc_pkg::ITER_W'(1);
          cidx  <= '0;
          if (conv || (iters + kmc_pkg::ITER_W'(1)) >= limit) begin
            state <= S_EMIT;
          end else begin
            conv   <= 1'b1;
            rd_ptr <= '0;
            state  <= S_SWEEP;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            if (last_c) begin
              pcount <= '0;
              state  <= S_IDLE;
            end else begin
              cidx <= cidx + kmc_pkg::IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_data.cluster_index <= cidx;
      out_data.cent_0        <= cent[cidx][0];
      out_data.cent_1        <= cent[cidx][1];
      out_data.cent_2        <= cent[cidx][2];
      out_data.cent_3        <= cent[cidx][3];
      if (state == S_CLS_OUT) begin
        out_data.result_kind    <= kmc_pkg::KIND_CLASS;
        out_data.converged      <= 1'b0;
        out_data.iterations_run <= '0;
        out_data.last_result    <= 1'b1;
      end else begin
        out_data.result_kind    <= kmc_pkg::KIND_CENTROID;
        out_data.converged      <= conv;
        out_data.iterations_run <= iters;
        out_data.last_result    <= last_c;
      end
    end
  end

  `KMC_ASSERT_NOW(a_pcount_bound, clk, rst, 1'b1, pcount <= kmc_pkg::CNT_W'(kmc_pkg::MAX_POINTS))
  `KMC_ASSERT_NOW(a_drained_before_update, clk, rst, state == S_UPDATE, !merge_valid && vpipe == '0)
  `KMC_ASSERT_NOW(a_div_done_in_wait, clk, rst, div_done, state == S_UPD_WAIT)
  `KMC_ASSERT_NEXT(a_emit_end_clears, clk, rst, state == S_EMIT && load_out && last_c, pcount == '0 && state == S_IDLE)

endmodule

>>> design/kmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module kmc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kmc_lane.sv
// One distance lane: pipelined squared distance to its centroid, plus the
// per-cluster coordinate sums and member count. Depends on kmc_pkg.
module kmc_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [kmc_pkg::DIM_W-1:0] dims,
  input  kmc_pkg::point_t          pt,
  input  kmc_pkg::point_t          cent,
  output logic [kmc_pkg::DIST_W-1:0] distance,
  input  kmc_pkg::lane_ctl_t       ctl,
  input  kmc_pkg::point_t          acc_pt,
  output kmc_pkg::acc_vec_t        sums,
  output logic [kmc_pkg::CNT_W-1:0] count
);

  logic signed [kmc_pkg::DIFF_W-1:0]   diff [kmc_pkg::MAX_DIMS];
  logic signed [2*kmc_pkg::DIFF_W-1:0] sq   [kmc_pkg::MAX_DIMS];
  logic [kmc_pkg::DIST_W-1:0]          distance_next;

  always_ff @(posedge clk) begin
    for (int j = 0; j < kmc_pkg::MAX_DIMS; j++) begin
      if (kmc_pkg::DIM_W'(j) < dims) begin
        diff[j] <= kmc_pkg::DIFF_W'($signed(pt[j])) - kmc_pkg::DIFF_W'($signed(cent[j]));
      end else begin
        diff[j] <= '0;
      end
      sq[j] <= diff[j] * diff[j];
    end
    distance <= distance_next;
  end

  always_comb begin
    distance_next = '0;
    for (int j = 0; j < kmc_pkg::MAX_DIMS; j++) begin
      distance_next = distance_next + kmc_pkg::DIST_W'($unsigned(sq[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sums  <= '0;
      count <= '0;
    end else if (ctl.acc) begin
      for (int j = 0; j < kmc_pkg::MAX_DIMS; j++) begin
        if (kmc_pkg::DIM_W'(j) < dims) begin
          sums[j] <= kmc_pkg::ACC_W'($signed(sums[j]) +
                     kmc_pkg::ACC_W'($signed(acc_pt[j])));
        end
      end
      count <= count + kmc_pkg::CNT_W'(1);
    end
  end

endmodule

>>> design/kmc_merge.sv
// Merging stage: registered argmin over the lane distances, lowest index
// wins ties. Depends on kmc_pkg.
module kmc_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  input  logic [kmc_pkg::MAX_CLUSTERS-1:0]              en,
  input  logic [kmc_pkg::MAX_CLUSTERS-1:0][kmc_pkg::DIST_W-1:0] distance,
  output logic                                          valid,
  output logic [kmc_pkg::IDX_W-1:0]                     idx
);

  logic [kmc_pkg::DIST_W-1:0] nd [2*kmc_pkg::MAX_CLUSTERS];
  logic [kmc_pkg::IDX_W-1:0]  ni [2*kmc_pkg::MAX_CLUSTERS];
  logic                       ne [2*kmc_pkg::MAX_CLUSTERS];

  always_comb begin
    for (int n = 0; n < 2 * kmc_pkg::MAX_CLUSTERS; n++) begin
      nd[n] = '0;
      ni[n] = '0;
      ne[n] = 1'b0;
    end
    for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) begin
      nd[kmc_pkg::MAX_CLUSTERS + i] = distance[i];
      ni[kmc_pkg::MAX_CLUSTERS + i] = kmc_pkg::IDX_W'(i);
      ne[kmc_pkg::MAX_CLUSTERS + i] = en[i];
    end
    for (int n = kmc_pkg::MAX_CLUSTERS - 1; n >= 1; n--) begin
      if (ne[2*n+1] && (!ne[2*n] || nd[2*n+1] < nd[2*n])) begin
        nd[n] = nd[2*n+1];
        ni[n] = ni[2*n+1];
      end else begin
        nd[n] = nd[2*n];
        ni[n] = ni[2*n];
      end
      ne[n] = ne[2*n] | ne[2*n+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
    idx <= ni[1];
  end

endmodule

>>> design/kmc_div.sv
// Restoring divider, one quotient bit per cycle: signed sum by unsigned
// member count, truncating toward zero. Depends on kmc_pkg.
module kmc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [kmc_pkg::ACC_W-1:0] dividend,
  input  logic [kmc_pkg::CNT_W-1:0]       divisor,
  output logic                            done,
  output kmc_pkg::coord_t                 quot
);

  localparam int STEP_W = $clog2(kmc_pkg::ACC_W + 1);

  logic                        busy;
  logic                        neg;
  logic [STEP_W-1:0]           step;
  logic [kmc_pkg::CNT_W-1:0]   dvs;
  logic [kmc_pkg::CNT_W-1:0]   rem;
  logic [kmc_pkg::ACC_W-1:0]   q;
  logic [kmc_pkg::CNT_W:0]     rem_sh;
  logic                        qbit;
  logic [kmc_pkg::ACC_W-1:0]   q_next;

  assign rem_sh = {rem, q[kmc_pkg::ACC_W-1]};
  assign qbit   = rem_sh >= {1'b0, dvs};
  assign q_next = {q[kmc_pkg::ACC_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend < 0;
        q    <= (dividend < 0) ? kmc_pkg::ACC_W'(-dividend) : kmc_pkg::ACC_W'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= qbit ? kmc_pkg::CNT_W'(rem_sh - {1'b0, dvs}) : kmc_pkg::CNT_W'(rem_sh);
        q    <= q_next;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(kmc_pkg::ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? kmc_pkg::COORD_W'(-q_next) : kmc_pkg::COORD_W'(q_next);
        end
      end
    end
  end

endmodule
